### sv/sdma_pkg.sv
// ----------------------------------------------------------------------------
// sdma_pkg
// Shared widths, constants and types of the stall detector.
// ----------------------------------------------------------------------------
package sdma_pkg;

  localparam int VEL_W = 16;          // one velocity component
  localparam int MAG_W = 16;          // magnitude, floor square root
  localparam int SQ_W  = 2 * MAG_W;   // sum of the three squares
  localparam int THR_W = 16;          // stall threshold register

  // Hysteresis factors: the sum is scaled by ten and compared against
  // nine or eleven times the threshold times the window length.
  localparam int SCALE_SUM = 10;
  localparam int SCALE_LO  = 9;
  localparam int SCALE_HI  = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_UPD,
    ST_CMP
  } sdma_state_t;

  // Status returned by the square root unit.
  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sdma_sqrt_sts_t;

endpackage

### sv/stall_detect_moving_average_hysteresis.sv
// ----------------------------------------------------------------------------
// stall_detect_moving_average_hysteresis
// Speed magnitude, moving average over a ring memory, hysteresis stall flag.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bit first)
//  in_      slave      vel_x[15:0], vel_y[31:16], vel_z[47:32]
//  out_     master     stuck[0], mode[1], mode_changed[2], magnitude[18:3]
//  cfg_     slave      stall_threshold[15:0]
//
// From acceptance to the next acceptance, when the result register is free,
// an item passes through the squares on one shared multiplier, the
// bit-per-cycle square root unit as it runs its sixteen steps and raises
// done, the ring update and the threshold compare, and then back to idle,
// where the next item is accepted. The result waits in an output register,
// so a new item is accepted while it is still held; only the compare stage
// stalls when the previous result has not been taken. Reset is synchronous;
// no clearing pass is needed, since a flag marks when the ring has wrapped.
// ----------------------------------------------------------------------------
module stall_detect_moving_average_hysteresis
  import sdma_pkg::*;
#(
  parameter int WINDOW = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // Velocity items: vel_x[15:0], vel_y[31:16], vel_z[47:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // Results: stuck[0], mode[1], mode_changed[2], magnitude[18:3], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // Threshold write: stall_threshold[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int SUM_W = PTR_W + MAG_W;
  localparam int CMP_W = SUM_W + 4;

  sdma_state_t state_r, state_nxt;

  // Captured components of the item in work.
  logic signed [VEL_W-1:0] vx_r, vy_r, vz_r;

  // Square and accumulate on one multiplier.
  logic [1:0]              cnt_r, cnt_nxt;
  logic signed [VEL_W-1:0] comp_sel;
  logic [SQ_W-1:0]         prod_r, prod_nxt;
  logic [SQ_W-1:0]         acc_r, acc_nxt;

  // Ring bookkeeping.
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             filled_r, filled_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [MAG_W-1:0] old_mag;

  // Flags and configuration.
  logic             stuck_r, stuck_nxt;
  logic             mode_r, mode_nxt;
  logic [THR_W-1:0] thr_r;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  // Compare terms.
  logic [CMP_W-1:0] sum10, lim, lim_lo, lim_hi;

  logic             accept;
  logic             sqrt_start;
  sdma_sqrt_sts_t   sqrt_sts;
  logic             ram_we;
  logic [MAG_W-1:0] ram_rd_data;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // The slot about to be overwritten is read as soon as the item arrives;
  // the read data holds until the ring update uses it.
  sdma_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ptr_r),
    .wr_data (mag_r),
    .rd_en   (accept),
    .rd_addr (ptr_r),
    .rd_data (ram_rd_data)
  );

  sdma_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_nxt),
    .sts      (sqrt_sts)
  );

  // Before the first wrap a slot has never been written and counts as zero.
  assign old_mag = filled_r ? ram_rd_data : '0;

  always_comb begin
    case (cnt_r)
      2'd0:    comp_sel = vx_r;
      2'd1:    comp_sel = vy_r;
      2'd2:    comp_sel = vz_r;
      default: comp_sel = '0;
    endcase
  end

  always_comb begin
    sum10  = CMP_W'(sum_r) * CMP_W'(SCALE_SUM);
    lim    = CMP_W'(thr_r) * CMP_W'(WINDOW);
    lim_lo = lim * CMP_W'(SCALE_LO);
    lim_hi = lim * CMP_W'(SCALE_HI);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = SQ_W'($signed(comp_sel) * $signed(comp_sel));
    acc_nxt       = acc_r;
    ptr_nxt       = ptr_r;
    filled_nxt    = filled_r;
    sum_nxt       = sum_r;
    mag_nxt       = mag_r;
    stuck_nxt     = stuck_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sqrt_start    = 1'b0;
    ram_we        = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        // The product of the previous cycle joins the accumulator.
        if (cnt_r != 2'd0) begin
          acc_nxt = acc_r + prod_r;
        end
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_sts.done) begin
          mag_nxt   = sqrt_sts.root;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ram_we  = 1'b1;
        sum_nxt = SUM_W'(sum_r - SUM_W'(old_mag) + SUM_W'(mag_r));
        if (ptr_r == PTR_W'(WINDOW - 1)) begin
          ptr_nxt    = '0;
          filled_nxt = 1'b1;
        end else begin
          ptr_nxt = PTR_W'(ptr_r + 1'b1);
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Wait here until the output register is free.
        if (!out_valid_r || out_tready) begin
          if (!stuck_r) begin
            stuck_nxt = (sum10 < lim_lo);
          end else begin
            stuck_nxt = !(sum10 > lim_hi);
          end
          // The mode simply follows the flag after its update.
          mode_nxt      = stuck_nxt;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b00000, mag_r, (mode_r != stuck_nxt), stuck_nxt, stuck_nxt};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      filled_r    <= 1'b0;
      sum_r       <= '0;
      stuck_r     <= 1'b0;
      mode_r      <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      filled_r    <= filled_nxt;
      sum_r       <= sum_nxt;
      stuck_r     <= stuck_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r <= in_tdata[15:0];
      vy_r <= in_tdata[31:16];
      vz_r <= in_tdata[47:32];
    end
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    mag_r      <= mag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/sdma_ram.sv
// ----------------------------------------------------------------------------
// sdma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sdma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sdma_isqrt.sv
// ----------------------------------------------------------------------------
// sdma_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sdma_isqrt
  import sdma_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output sdma_sqrt_sts_t  sts
);

  localparam int CNT_W = $clog2(MAG_W);
  localparam int REM_W = MAG_W + 2;

  logic [SQ_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    // Bring down the next two radicand bits and try a one in the root.
    rem_sh   = {rem_r, rad_r[SQ_W-1 -: 2]};
    trial    = {2'b00, q_r, 2'b01};
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt = REM_W'(rem_sh - trial);
        q_nxt   = {q_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = REM_W'(rem_sh);
        q_nxt   = {q_r[MAG_W-2:0], 1'b0};
      end
      rad_nxt = {rad_r[SQ_W-3:0], 2'b00};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign sts.done = done_r;
  assign sts.root = q_r;

endmodule
